// ===== rtl/rtsc_pkg.sv =====
// Shared types, constants and helper functions for the rolling table substitution cipher.
// Holds the cipher alphabet, its inverse, register indexes and mod-26 arithmetic.
// No dependencies.
`default_nettype none

package rtsc_pkg;

    localparam int unsigned ALPHA_LEN = 26;

    // ASCII anchors
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;

    // Configuration register indexes
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd0;
    localparam logic [1:0] REG_FIRST_SHIFT  = 2'd1;
    localparam logic [1:0] REG_SECOND_SHIFT = 2'd2;

    typedef logic [4:0] alpha_idx_t;

    // Letter class of one input byte
    typedef struct packed {
        logic is_upper;
        logic is_lower;
    } letter_class_t;

    // Cipher alphabet: position -> lowercase letter
    localparam logic [7:0] CIPHER_ALPHA [ALPHA_LEN] = '{
        "k", "o", "e", "g", "b", "p", "d", "w", "i", "t", "n", "c", "m",
        "f", "r", "y", "q", "z", "u", "l", "a", "s", "h", "x", "v", "j"
    };

    // Inverse: lowercase letter index ('a' = 0) -> position in the cipher alphabet
    localparam alpha_idx_t INV_ALPHA [ALPHA_LEN] = '{
        5'd20, 5'd4,  5'd11, 5'd6,  5'd2,  5'd13, 5'd3,  5'd22, 5'd8,
        5'd25, 5'd0,  5'd19, 5'd12, 5'd10, 5'd1,  5'd5,  5'd16, 5'd14,
        5'd21, 5'd9,  5'd18, 5'd24, 5'd7,  5'd23, 5'd15, 5'd17
    };

    function automatic letter_class_t classify(input logic [7:0] b);
        letter_class_t c;
        c.is_upper = b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]};
        c.is_lower = b inside {[ASCII_LOWER_A:ASCII_LOWER_Z]};
        return c;
    endfunction

    // Fold a 5-bit value into 0..25
    function automatic alpha_idx_t reduce26(input logic [4:0] v);
        logic [4:0] r;
        r = (v >= 5'(ALPHA_LEN)) ? v - 5'(ALPHA_LEN) : v;
        return r;
    endfunction

    // (a + b) mod 26, both operands already in 0..25
    function automatic alpha_idx_t add26(input alpha_idx_t a, input alpha_idx_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'(ALPHA_LEN))
        begin
            s = s - 6'(ALPHA_LEN);
        end
        return s[4:0];
    endfunction

    // (a - b) mod 26, both operands already in 0..25
    function automatic alpha_idx_t sub26(input alpha_idx_t a, input alpha_idx_t b);
        logic [5:0] s;
        s = {1'b0, a} + 6'(ALPHA_LEN) - {1'b0, b};
        if (s >= 6'(ALPHA_LEN))
        begin
            s = s - 6'(ALPHA_LEN);
        end
        return s[4:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtsc_offset.sv =====
// Letter phase and shift offset tracker for the rolling substitution cipher.
// Gives the offset that applies to the current letter and steps the state.
// Depends on rtsc_pkg.
`default_nettype none

module rtsc_offset
    import rtsc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step_en,
    input  wire letter_class_t cls,
    input  wire logic [4:0]    first_shift,
    input  wire logic [4:0]    second_shift,
    output alpha_idx_t         offset
);

    typedef enum logic [2:0] {
        PH_NONE   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    alpha_idx_t offset_reg;
    alpha_idx_t offset_next;
    logic       is_letter;

    assign is_letter = cls.is_upper | cls.is_lower;

    // Offset for this letter: zero on the first, then alternating decrements
    always_comb
    begin
        case (phase_reg)
            PH_NONE:
            begin
                offset_next = '0;
                phase_next  = PH_FIRST;
            end
            PH_FIRST:
            begin
                offset_next = sub26(offset_reg, reduce26(first_shift));
                phase_next  = PH_SECOND;
            end
            default:
            begin
                offset_next = sub26(offset_reg, reduce26(second_shift));
                phase_next  = PH_FIRST;
            end
        endcase
    end

    assign offset = offset_next;

    // State advances only on letters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NONE;
            offset_reg <= '0;
        end
        else if (step_en && is_letter)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtsc_subst.sv =====
// Combinational substitution datapath: table lookup for encrypt, inverse lookup for decrypt.
// Non-letters, and uppercase letters in decrypt mode, pass through.
// Depends on rtsc_pkg.
`default_nettype none

module rtsc_subst
    import rtsc_pkg::*;
(
    input  wire logic [7:0]    in_byte,
    input  wire letter_class_t cls,
    input  wire logic          decrypt_mode,
    input  wire alpha_idx_t    offset,
    output logic [7:0]         out_byte
);

    logic [7:0] rel;
    alpha_idx_t letter_idx;
    alpha_idx_t enc_idx;
    alpha_idx_t dec_idx;
    logic [7:0] enc_byte;
    logic [7:0] dec_byte;

    // Alphabet index of the letter (0..25 for either case)
    assign rel        = in_byte - (cls.is_upper ? ASCII_UPPER_A : ASCII_LOWER_A);
    assign letter_idx = reduce26(rel[4:0]);

    // Encrypt: rotate into the cipher alphabet
    assign enc_idx  = add26(letter_idx, offset);
    assign enc_byte = CIPHER_ALPHA[enc_idx];

    // Decrypt: find position in the cipher alphabet, rotate back, emit uppercase
    assign dec_idx  = sub26(INV_ALPHA[letter_idx], offset);
    assign dec_byte = ASCII_UPPER_A + {3'b000, dec_idx};

    always_comb
    begin
        out_byte = in_byte;
        if (!decrypt_mode && (cls.is_upper || cls.is_lower))
        begin
            out_byte = enc_byte;
        end
        else if (decrypt_mode && cls.is_lower)
        begin
            out_byte = dec_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rolling_table_substitution_cipher_core.sv =====
// Top level of the rolling table substitution cipher: stream ports, config registers,
// input and result registers around the offset tracker and substitution datapath.
// Depends on rtsc_pkg, rtsc_offset, rtsc_subst.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata[7:0] = in_byte
//  m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata[7:0] = out_byte
//  cfg       in         cfg_we (no wait)               cfg_index, cfg_data[4:0]
//
// One item per cycle sustained while m_axis_tready stays high.
// The offset update and table lookup sit between the input register and the result
// register. A full result register with m_axis_tready low holds the input register,
// and s_axis_tready drops only when both are occupied.
// rst_n clears the valid flags, the config registers, the phase and the offset.
`default_nettype none

module rolling_table_substitution_cipher_core
    import rtsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data
);

    logic          decrypt_mode_reg;
    logic [4:0]    first_shift_reg;
    logic [4:0]    second_shift_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          in_accept;
    logic          advance;
    letter_class_t cls;
    alpha_idx_t    offset;
    logic [7:0]    result_byte;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
            first_shift_reg  <= '0;
            second_shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                REG_FIRST_SHIFT:  first_shift_reg  <= cfg_data;
                REG_SECOND_SHIFT: second_shift_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign cls = classify(in_byte_reg);

    rtsc_offset u_offset (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .cls          (cls),
        .first_shift  (first_shift_reg),
        .second_shift (second_shift_reg),
        .offset       (offset)
    );

    rtsc_subst u_subst (
        .in_byte      (in_byte_reg),
        .cls          (cls),
        .decrypt_mode (decrypt_mode_reg),
        .offset       (offset),
        .out_byte     (result_byte)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= result_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

endmodule

`default_nettype wire

// ===== rtl/rtsc_checker.sv =====
// Port-level checks for the rolling table substitution cipher core.
// Bound to rolling_table_substitution_cipher_core; no package dependency.
`default_nettype none

module rtsc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       in_acc;
    logic       out_acc;
    logic       unused_data;

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign out_acc     = m_axis_tvalid && m_axis_tready;
    assign unused_data = ^s_axis_tdata;

    // Items inside the core
    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // Downstream ready always frees the input side
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // No more than two items in flight, and no result without an item
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != 2'd3) && (!m_axis_tvalid || occ_reg != 2'd0) && (unused_data || 1'b1))
        else $error("item count out of bounds");

    // Two items held with output stalled: input must stall
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == 2'd2) && !m_axis_tready |-> !s_axis_tready)
        else $error("accepted an item with both registers full");

endmodule

bind rolling_table_substitution_cipher_core rtsc_checker u_rtsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for rolling_table_substitution_cipher_core: a directed table, then random byte
// streams under changing config, each result checked against a rolling-offset predictor.
// Depends on rtsc_pkg (register indexes) and the core RTL.
module tb;
    import rtsc_pkg::*;

    localparam int IDLE_PCT       = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 48;
    localparam int END_DRAIN      = 10;

    // Cipher alphabet, position 0 in the top byte
    localparam logic [8*26-1:0] KEY_ALPHABET = "koegbpdwitncmfryqzulashxvj";

    typedef enum logic [1:0] {PH_START, PH_FIRST, PH_SECOND} letter_phase_t;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] idx;
        logic [7:0] data;
        bit         known;
        logic [7:0] want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    // Predictor copy of config and cipher state
    logic          cfg_decrypt = 1'b0;
    logic [4:0]    cfg_shift1  = '0;
    logic [4:0]    cfg_shift2  = '0;
    letter_phase_t pred_phase  = PH_START;
    int            pred_offset = 0;

    logic [7:0] expected_bytes [$];
    stim_row_t  directed [$];
    int         errors      = 0;
    int         idle_cycles = 0;
    bit         quiet       = 1'b0;

    rolling_table_substitution_cipher_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] alpha_at(input int pos);
        return KEY_ALPHABET[8*(25-pos) +: 8];
    endfunction

    function automatic int sub_mod26(input int a, input int b);
        return (a % 26 + 26 - b % 26) % 26;
    endfunction

    // Advance the rolling offset on letters and return the ciphered byte
    function automatic logic [7:0] cipher_byte(input logic [7:0] b);
        logic       up;
        logic       lo;
        int         k;
        int         pos;
        logic [7:0] res;
        up  = (b >= 8'd65) && (b <= 8'd90);
        lo  = (b >= 8'd97) && (b <= 8'd122);
        res = b;
        if (up || lo)
        begin
            case (pred_phase)
                PH_START:
                begin
                    pred_offset = 0;
                    pred_phase  = PH_FIRST;
                end
                PH_FIRST:
                begin
                    pred_offset = sub_mod26(pred_offset, cfg_shift1);
                    pred_phase  = PH_SECOND;
                end
                default:
                begin
                    pred_offset = sub_mod26(pred_offset, cfg_shift2);
                    pred_phase  = PH_FIRST;
                end
            endcase
            if (!cfg_decrypt)
            begin
                k   = up ? int'(b) - 65 : int'(b) - 97;
                res = alpha_at((k + pred_offset) % 26);
            end
            else if (lo)
            begin
                pos = 0;
                for (int i = 0; i < 26; i++)
                begin
                    if (alpha_at(i) == b)
                        pos = i;
                end
                res = 8'(65 + sub_mod26(pos, pred_offset));
            end
        end
        return res;
    endfunction

    function automatic stim_row_t item_row(input logic [7:0] b);
        stim_row_t r;
        r = '{ROW_ITEM, 2'd0, b, 1'b0, 8'd0};
        return r;
    endfunction

    function automatic stim_row_t item_chk(input logic [7:0] b, input logic [7:0] want);
        stim_row_t r;
        r = '{ROW_ITEM, 2'd0, b, 1'b1, want};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [7:0] v);
        stim_row_t r;
        r = '{ROW_CFG, idx, v, 1'b0, 8'd0};
        return r;
    endfunction

    // Mostly letters of both cases, the rest any byte
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return 8'($urandom_range(90, 65));
        else if (r < 75)
            return 8'($urandom_range(122, 97));
        return 8'($urandom_range(255));
    endfunction

    // Shift values, weighted toward the ends and the out-of-range codes
    function automatic logic [4:0] rand_shift();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 5'd0;
        else if (r == 1)
            return 5'd25;
        else if (r == 2)
            return 5'($urandom_range(31, 26));
        return 5'($urandom_range(25));
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Offer one item, wait for the handshake, log its expected result
    task automatic send_item(input logic [7:0] b, input bit known, input logic [7:0] want);
        logic [7:0] got;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = cipher_byte(b);
        expected_bytes.push_back(known ? want : got);
        @(negedge clk);
    endtask

    // Hold off the input until every result is back
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] v);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        case (idx)
            REG_DECRYPT_MODE: cfg_decrypt = v[0];
            REG_FIRST_SHIFT:  cfg_shift1  = v;
            REG_SECOND_SHIFT: cfg_shift2  = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Result side: random backpressure
    always @(negedge clk)
        m_axis_tready = quiet || ($urandom_range(99) >= IDLE_PCT);

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected out 0x%02h", m_axis_tdata));
            else
            begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch($sformatf("out 0x%02h, expected 0x%02h",
                                              m_axis_tdata, want));
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: watchdog expired, %0d results pending", expected_bytes.size());
            $display("tb: errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;

        directed = '{
            // reset config: offset stays 0, so plain table lookups
            item_chk("A", "k"), item_chk("z", "j"), item_chk("Z", "j"), item_chk("a", "k"),
            // bytes outside the letter ranges, at their edges and beyond, pass through
            item_chk(8'h00, 8'h00), item_chk(8'hFF, 8'hFF), item_chk("@", "@"),
            item_chk("[", "["), item_chk(8'h60, 8'h60), item_chk("{", "{"),
            item_chk(8'h80, 8'h80),
            cfg_row(REG_FIRST_SHIFT, 8'd3), cfg_row(REG_SECOND_SHIFT, 8'd25),
            item_row("H"), item_row("e"), item_row("l"), item_row("l"), item_row("o"),
            item_chk(" ", " "),
            // shift code above 25 folds mod 26
            cfg_row(REG_FIRST_SHIFT, 8'd31), cfg_row(REG_SECOND_SHIFT, 8'd0),
            item_row("W"), item_row("o"),
            // decrypt mid-stream: offset carries on, uppercase passes but advances
            cfg_row(REG_DECRYPT_MODE, 8'd1),
            item_row("k"), item_row("j"), item_row("a"), item_chk("Q", "Q"),
            item_chk("5", "5"),
            cfg_row(REG_SECOND_SHIFT, 8'd26),
            item_row("x")
        };

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx, directed[i].data[4:0]);
            else
                send_item(directed[i].data, directed[i].known, directed[i].want);
        end

        // Random phases, config rewritten between them
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_DECRYPT_MODE, 5'($urandom_range(1)));
            write_reg(REG_FIRST_SHIFT, (p == 1) ? 5'd25 : rand_shift());
            write_reg(REG_SECOND_SHIFT, (p == 1) ? 5'd31 : rand_shift());
            quiet = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(rand_byte(), 1'b0, 8'd0);
                if (p == 5 && n == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (END_DRAIN) @(negedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rtsc_pkg.sv
rtl/rtsc_offset.sv
rtl/rtsc_subst.sv
rtl/rolling_table_substitution_cipher_core.sv
rtl/rtsc_checker.sv
dv/tb.sv
